FILE: hdl/nmea_lat_lon_field_parser_top_macros.svh
// Assertion macros shared by the NMEA latitude and longitude parser modules.
`ifndef NMEA_LAT_LON_FIELD_PARSER_TOP_MACROS_SVH
`define NMEA_LAT_LON_FIELD_PARSER_TOP_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define NMEA_LL_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NMEA_LL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define NMEA_LL_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hdl/nmea_ll_pkg.sv
// Types, constants and helper functions of the NMEA latitude and longitude parser.
package nmea_ll_pkg;

	localparam int FRAC_DIGITS_DEF = 4;
	localparam int MAX_LINE_DEF = 100;

	localparam int CHAR_W = 8;
	localparam int MAG_W = 30;
	localparam int VAL_W = 31;
	localparam int FRAC_CNT_W = 3;
	localparam int FIELD_W = 4;
	localparam int POW10_W = 20;
	localparam int PROD_W = MAG_W + POW10_W;
	localparam int S_DATA_W = 8;
	localparam int M_DATA_W = 72;

	localparam logic [MAG_W-1:0] MAG_MAX = MAG_W'(999999999);
	localparam logic [MAG_W-1:0] MAG_DIV10 = MAG_W'(99999999);

	localparam logic [CHAR_W-1:0] CH_NL = 8'd10;
	localparam logic [CHAR_W-1:0] CH_CR = 8'd13;
	localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2c;
	localparam logic [CHAR_W-1:0] CH_POINT = 8'h2e;
	localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
	localparam logic [CHAR_W-1:0] CH_S = 8'h53;
	localparam logic [CHAR_W-1:0] CH_W = 8'h57;

	localparam logic [FIELD_W-1:0] FIELD_LAT = 4'd2;
	localparam logic [FIELD_W-1:0] FIELD_LAT_HEMI = 4'd3;
	localparam logic [FIELD_W-1:0] FIELD_LON = 4'd4;
	localparam logic [FIELD_W-1:0] FIELD_LON_HEMI = 4'd5;
	localparam logic [FIELD_W-1:0] FIELD_MAX = 4'd15;

	typedef struct packed {
		logic clear;
		logic acc_en;
		logic neg_set;
	} coord_ctl_t;

	function automatic logic [POW10_W-1:0] pow10(input logic [FRAC_CNT_W-1:0] k);
		logic [POW10_W-1:0] p;
		case (k)
			3'd0: p = POW10_W'(1);
			3'd1: p = POW10_W'(10);
			3'd2: p = POW10_W'(100);
			3'd3: p = POW10_W'(1000);
			3'd4: p = POW10_W'(10000);
			3'd5: p = POW10_W'(100000);
			3'd6: p = POW10_W'(1000000);
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

FILE: hdl/nmea_ll_line.sv
// Line tracking: comma count, field start flag and line length, with per-coordinate control.
module nmea_ll_line #(
	parameter int MaxLine = nmea_ll_pkg::MAX_LINE_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 process,
	input  logic [nmea_ll_pkg::CHAR_W-1:0]       rx_char,
	output nmea_ll_pkg::coord_ctl_t              lat_ctl,
	output nmea_ll_pkg::coord_ctl_t              lon_ctl,
	output logic [nmea_ll_pkg::FIELD_W-1:0]      fields_seen
);
	import nmea_ll_pkg::*;

	localparam int LenW = $clog2(MaxLine + 1);

	logic [FIELD_W-1:0] field_q;
	logic               start_q;
	logic [LenW-1:0]    len_q;
	logic               is_nl;
	logic               counted;
	logic               is_comma;
	logic               body;

	assign is_nl = (rx_char == CH_NL);
	assign counted = process && !is_nl && (rx_char != CH_CR) && (len_q < LenW'(MaxLine));
	assign is_comma = (rx_char == CH_COMMA);
	assign body = counted && !is_comma;

	always_comb begin
		lat_ctl.clear = process && is_nl;
		lon_ctl.clear = process && is_nl;
		lat_ctl.acc_en = body && (field_q == FIELD_LAT);
		lon_ctl.acc_en = body && (field_q == FIELD_LON);
		lat_ctl.neg_set = body && start_q && (field_q == FIELD_LAT_HEMI) && (rx_char == CH_S);
		lon_ctl.neg_set = body && start_q && (field_q == FIELD_LON_HEMI) && (rx_char == CH_W);
	end

	assign fields_seen = field_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q <= '0;
			start_q <= 1'b1;
			len_q <= '0;
		end else if (process && is_nl) begin
			field_q <= '0;
			start_q <= 1'b1;
			len_q <= '0;
		end else if (counted) begin
			len_q <= len_q + LenW'(1);
			if (is_comma) begin
				if (field_q != FIELD_MAX) begin
					field_q <= field_q + FIELD_W'(1);
				end
				start_q <= 1'b1;
			end else begin
				start_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hdl/nmea_ll_coord.sv
// One coordinate accumulator: decimal digits to a saturating fixed-point magnitude and sign.
`include "nmea_lat_lon_field_parser_top_macros.svh"

module nmea_ll_coord #(
	parameter int FracDigits = nmea_ll_pkg::FRAC_DIGITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  nmea_ll_pkg::coord_ctl_t          ctl,
	input  logic [nmea_ll_pkg::CHAR_W-1:0]   rx_char,
	output logic [nmea_ll_pkg::VAL_W-1:0]    value
);
	import nmea_ll_pkg::*;

	logic [MAG_W-1:0]      mag_q;
	logic [FRAC_CNT_W-1:0] frac_q;
	logic                  point_q;
	logic                  neg_q;
	logic                  is_digit;
	logic                  take_digit;
	logic [MAG_W-1:0]      mag_next;
	logic [MAG_W-1:0]      times_ten;
	logic [FRAC_CNT_W-1:0] pad_count;
	logic [PROD_W-1:0]     padded;
	logic [MAG_W-1:0]      mag_sat;
	logic [VAL_W-1:0]      mag_ext;

	assign is_digit = (rx_char >= CH_ZERO) && (rx_char <= CH_NINE);
	assign take_digit = is_digit && (!point_q || (frac_q < FRAC_CNT_W'(FracDigits)));

	always_comb begin
		times_ten = (mag_q << 3) + (mag_q << 1) + MAG_W'(rx_char[3:0]);
		if (mag_q > MAG_DIV10) begin
			mag_next = MAG_MAX;
		end else if (times_ten > MAG_MAX) begin
			mag_next = MAG_MAX;
		end else begin
			mag_next = times_ten;
		end
	end

	// Missing fraction digits are filled in by one scale by a power of ten.
	assign pad_count = FRAC_CNT_W'(FracDigits) - frac_q;
	assign padded = PROD_W'(mag_q) * PROD_W'(pow10(pad_count));
	assign mag_sat = (padded > PROD_W'(MAG_MAX)) ? MAG_MAX : padded[MAG_W-1:0];
	assign mag_ext = {1'b0, mag_sat};
	assign value = neg_q ? (VAL_W'(0) - mag_ext) : mag_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q <= '0;
			frac_q <= '0;
			point_q <= 1'b0;
			neg_q <= 1'b0;
		end else if (ctl.clear) begin
			mag_q <= '0;
			frac_q <= '0;
			point_q <= 1'b0;
			neg_q <= 1'b0;
		end else begin
			if (ctl.acc_en) begin
				if (take_digit) begin
					mag_q <= mag_next;
					if (point_q) begin
						frac_q <= frac_q + FRAC_CNT_W'(1);
					end
				end else if (rx_char == CH_POINT) begin
					point_q <= 1'b1;
				end
			end
			if (ctl.neg_set) begin
				neg_q <= 1'b1;
			end
		end
	end

	`NMEA_LL_ASSERT_ALWAYS(a_mag_range, mag_q <= MAG_MAX, "Magnitude above saturation limit.")
	`NMEA_LL_ASSERT_ALWAYS(a_frac_range, frac_q <= FRAC_CNT_W'(FracDigits), "Too many fraction digits.")
	`NMEA_LL_ASSERT_SAME(a_frac_point, !point_q, frac_q == '0, "Fraction digits without a point.")

endmodule

FILE: hdl/nmea_lat_lon_field_parser_top.sv
// Top level of the NMEA latitude and longitude field parser.
//
// Channel  Direction  Carries
// s_*      in         one received character per request
// m_*      out        latitude, longitude and comma count, one request per newline
//
// Each character is taken into an input register and processed from there; results
// appear in the cycle after the newline is processed. A new character can be accepted
// every cycle unless the input stalls, which it does only while a newline waits and the
// output register still holds a result. Reset clears the line state and both valid flags.
`include "nmea_lat_lon_field_parser_top_macros.svh"

module nmea_lat_lon_field_parser_top #(
	parameter int FracDigits = nmea_ll_pkg::FRAC_DIGITS_DEF,
	parameter int MaxLine = nmea_ll_pkg::MAX_LINE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// rx_char[7:0]
	input  logic [nmea_ll_pkg::S_DATA_W-1:0]   s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// latitude_value[30:0], longitude_value[61:31], fields_seen[65:62], zeros[71:66]
	output logic [nmea_ll_pkg::M_DATA_W-1:0]   m_tdata
);
	import nmea_ll_pkg::*;

	logic                  valid_s1;
	logic [CHAR_W-1:0]     char_s1;
	logic                  is_nl;
	logic                  proceed;
	coord_ctl_t            lat_ctl;
	coord_ctl_t            lon_ctl;
	logic [FIELD_W-1:0]    fields_seen;
	logic [VAL_W-1:0]      lat_value;
	logic [VAL_W-1:0]      lon_value;
	logic [VAL_W-1:0]      lat_q;
	logic [VAL_W-1:0]      lon_q;
	logic [FIELD_W-1:0]    fields_q;
	logic                  out_valid_q;

	assign is_nl = (char_s1 == CH_NL);
	assign proceed = valid_s1 && (!is_nl || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || proceed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (proceed) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata[CHAR_W-1:0];
		end
	end

	nmea_ll_line #(
		.MaxLine(MaxLine)
	) u_line (
		.clk(clk),
		.arst_n(arst_n),
		.process(proceed),
		.rx_char(char_s1),
		.lat_ctl(lat_ctl),
		.lon_ctl(lon_ctl),
		.fields_seen(fields_seen)
	);

	nmea_ll_coord #(
		.FracDigits(FracDigits)
	) u_lat (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(lat_ctl),
		.rx_char(char_s1),
		.value(lat_value)
	);

	nmea_ll_coord #(
		.FracDigits(FracDigits)
	) u_lon (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(lon_ctl),
		.rx_char(char_s1),
		.value(lon_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proceed && is_nl) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proceed && is_nl) begin
			lat_q <= lat_value;
			lon_q <= lon_value;
			fields_q <= fields_seen;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {(M_DATA_W - 2 * VAL_W - FIELD_W)'(0), fields_q, lon_q, lat_q};

	`NMEA_LL_ASSERT_NEXT(a_nl_result, proceed && is_nl, m_tvalid, "Newline gave no result.")
	`NMEA_LL_ASSERT_NEXT(a_hold_s1, valid_s1 && !proceed, valid_s1 && $stable(char_s1), "Held character lost.")
	`NMEA_LL_ASSERT_SAME(a_nl_stall, valid_s1 && is_nl && m_tvalid && !m_tready, !s_tready, "Input taken while newline blocked.")

endmodule

FILE: verif/nmea_lat_lon_field_parser_top_tb.sv
// Self-checking testbench: NMEA lines in, latitude/longitude results checked against a local predictor.
module nmea_lat_lon_field_parser_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import nmea_ll_pkg::*;

	localparam int FRAC = FRAC_DIGITS_DEF;
	localparam int LINE_MAX = MAX_LINE_DEF;
	localparam int MIN_CHARS = 1900;
	localparam int MIN_LINES = 60;
	localparam int MAX_WAIT = 12;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic hold;
	} char_req_t;

	typedef struct packed {
		logic [VAL_W-1:0] lat;
		logic [VAL_W-1:0] lon;
		logic [FIELD_W-1:0] fields;
	} fix_t;

	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic [FRAC_CNT_W-1:0] frac;
		logic point;
		logic neg;
	} coord_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	logic [FIELD_W-1:0] field_idx;
	logic field_first;
	logic [6:0] line_count;
	coord_t lat_acc;
	coord_t lon_acc;

	fix_t expected_fixes[$];
	char_req_t char_queue[$];
	bit hold_next;
	int chars_total;
	int chars_sent;
	int lines_made;
	int fixes_checked;
	int errors;
	int tx_gap;
	bit tx_lazy;
	int rx_stall;
	bit rx_lazy;
	int cycles;

	nmea_lat_lon_field_parser_top #(
		.FracDigits(FRAC),
		.MaxLine(LINE_MAX)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [MAG_W-1:0] scale_digit(logic [MAG_W-1:0] m, logic [3:0] d);
		logic [MAG_W+3:0] wide;
		if (m > MAG_DIV10)
			return MAG_MAX;
		wide = (MAG_W+4)'(m) * 10 + d;
		return (wide > MAG_MAX) ? MAG_MAX : wide[MAG_W-1:0];
	endfunction

	function automatic coord_t coord_step(coord_t a, logic [CHAR_W-1:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) begin
			if (a.point) begin
				if (a.frac >= FRAC)
					return a;
				a.frac++;
			end
			a.mag = scale_digit(a.mag, 4'(c - CH_ZERO));
		end else if (c == CH_POINT) begin
			a.point = 1'b1;
		end
		return a;
	endfunction

	function automatic logic [VAL_W-1:0] coord_value(coord_t a);
		logic [MAG_W-1:0] m;
		logic [VAL_W-1:0] v;
		m = a.mag;
		for (int i = a.frac; i < FRAC; i++)
			m = scale_digit(m, 4'd0);
		v = {1'b0, m};
		return a.neg ? -v : v;
	endfunction

	function automatic void reset_line();
		field_idx = '0;
		field_first = 1'b1;
		line_count = '0;
		lat_acc = '0;
		lon_acc = '0;
	endfunction

	task automatic parse_char(input logic [CHAR_W-1:0] c);
		logic first;
		fix_t fix;
		if (c == CH_NL) begin
			fix.lat = coord_value(lat_acc);
			fix.lon = coord_value(lon_acc);
			fix.fields = field_idx;
			expected_fixes.push_back(fix);
			reset_line();
		end else if (c != CH_CR && line_count < LINE_MAX) begin
			line_count++;
			if (c == CH_COMMA) begin
				if (field_idx != FIELD_MAX)
					field_idx++;
				field_first = 1'b1;
			end else begin
				first = field_first;
				field_first = 1'b0;
				case (field_idx)
					FIELD_LAT: lat_acc = coord_step(lat_acc, c);
					FIELD_LAT_HEMI: if (first && c == CH_S) lat_acc.neg = 1'b1;
					FIELD_LON: lon_acc = coord_step(lon_acc, c);
					FIELD_LON_HEMI: if (first && c == CH_W) lon_acc.neg = 1'b1;
					default: ;
				endcase
			end
		end
	endtask

	task automatic put_char(input logic [CHAR_W-1:0] c);
		char_req_t req;
		req.ch = c;
		req.hold = hold_next;
		hold_next = 1'b0;
		char_queue.push_back(req);
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_char(s[i]);
	endtask

	task automatic end_line(input bit with_cr);
		if (with_cr)
			put_char(CH_CR);
		put_char(CH_NL);
		lines_made++;
	endtask

	task automatic put_digits(input int n);
		repeat (n) put_char(CHAR_W'(CH_ZERO + $urandom_range(0, 9)));
	endtask

	task automatic put_number();
		string junk = "-+A.x/";
		put_digits(($urandom_range(0, 7) == 0) ? $urandom_range(0, 11) : $urandom_range(3, 5));
		if ($urandom_range(0, 11) == 0)
			put_char(junk[$urandom_range(0, junk.len() - 1)]);
		if ($urandom_range(0, 7) != 0) begin
			put_char(CH_POINT);
			put_digits($urandom_range(0, 8));
		end
	endtask

	task automatic put_mark(input logic [CHAR_W-1:0] neg_mark, input string pos_mark);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: put_char(neg_mark);
			4, 5, 6: put_text(pos_mark);
			7: put_char(neg_mark + 8'h20);
			8: ;
			default: begin
				put_text("X");
				put_char(neg_mark);
			end
		endcase
	endtask

	task automatic put_fix_line();
		put_text("$GPGGA,");
		put_digits(6);
		put_text(".00,");
		put_number();
		put_char(CH_COMMA);
		put_mark(CH_S, "N");
		put_char(CH_COMMA);
		put_number();
		put_char(CH_COMMA);
		put_mark(CH_W, "E");
		if ($urandom_range(0, 3) == 0)
			put_text(",1,08,0.9,545.4,M,46.9,M,,*47");
		end_line(1'($urandom_range(0, 1)));
	endtask

	task automatic put_noise_line(input int n);
		string pick = ",,,..0123456789SWNEx-";
		repeat (n) begin
			if ($urandom_range(0, 3) == 0)
				put_char(CHAR_W'($urandom_range(11, 255)));
			else
				put_char(pick[$urandom_range(0, pick.len() - 1)]);
		end
		end_line(0);
	endtask

	task automatic put_raw_line();
		repeat ($urandom_range(1, 20)) put_char(CHAR_W'($urandom_range(0, 255)));
		end_line(0);
	endtask

	task automatic build_stimulus();
		int kind;
		end_line(0);
		put_text(",,4807.038,N,01131.000,E");
		end_line(1);
		put_text(",,12.3456789,S,123,W");
		end_line(0);
		put_text(",,9999999999,s,.5.5x-,WS");
		put_char(8'hff);
		put_char(8'h00);
		end_line(0);
		put_text(",,,S,,W");
		end_line(0);
		put_text(",,99999999,N,100000000,E,,,,,,,,,,,,,,");
		end_line(0);
		// The carriage return does not count toward the line length, so the
		// comma right after the filler is the last character looked at.
		put_text(",,1");
		put_char(CH_CR);
		repeat (LINE_MAX - 4) put_char("x");
		put_text(",,5");
		end_line(0);
		hold_next = 1'b1;
		while (char_queue.size() < MIN_CHARS || lines_made < MIN_LINES) begin
			if (lines_made % 12 == 0)
				hold_next = 1'b1;
			kind = $urandom_range(0, 99);
			if (kind < 70)
				put_fix_line();
			else if (kind < 82)
				put_noise_line($urandom_range(1, 30));
			else if (kind < 90)
				put_noise_line($urandom_range(LINE_MAX - 4, LINE_MAX + 30));
			else
				put_raw_line();
		end
		chars_total = char_queue.size();
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic next_valid;
		logic [CHAR_W-1:0] next_data;
		char_req_t req;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			tx_gap = 0;
		end else begin
			next_valid = s_tvalid;
			next_data = s_tdata;
			if (s_tvalid && s_tready) begin
				parse_char(s_tdata);
				chars_sent++;
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (char_queue.size() != 0 &&
						!(char_queue[0].hold && expected_fixes.size() != 0)) begin
					req = char_queue.pop_front();
					next_data = req.ch;
					next_valid = 1'b1;
					if ($urandom_range(0, 149) == 0)
						tx_lazy = !tx_lazy;
					tx_gap = tx_lazy ? $urandom_range(0, MAX_WAIT) : 0;
				end
			end
			s_tvalid <= next_valid;
			s_tdata <= next_data;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		fix_t got;
		fix_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.lat = m_tdata[VAL_W-1:0];
				got.lon = m_tdata[2*VAL_W-1:VAL_W];
				got.fields = m_tdata[2*VAL_W +: FIELD_W];
				if (expected_fixes.size() == 0) begin
					$error("result with no line pending: %h", m_tdata);
					errors++;
				end else begin
					want = expected_fixes.pop_front();
					if (got.lat !== want.lat) begin
						$error("latitude_value: expected %0d, got %0d",
							$signed(want.lat), $signed(got.lat));
						errors++;
					end
					if (got.lon !== want.lon) begin
						$error("longitude_value: expected %0d, got %0d",
							$signed(want.lon), $signed(got.lon));
						errors++;
					end
					if (got.fields !== want.fields) begin
						$error("fields_seen: expected %0d, got %0d", want.fields, got.fields);
						errors++;
					end
					fixes_checked++;
				end
				if ($urandom_range(0, 29) == 0)
					rx_lazy = !rx_lazy;
				rx_stall = rx_lazy ? $urandom_range(0, MAX_WAIT) : 0;
			end else if (rx_stall > 0) begin
				rx_stall--;
			end
			m_tready <= (rx_stall == 0);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		reset_line();
		tx_lazy = 1'b1;
		rx_lazy = 1'b1;
		build_stimulus();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (chars_sent != chars_total)
			@(posedge clk);
		while (expected_fixes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		$display("Sent %0d lines (%0d characters) with random sender gaps and receiver stalls;",
			lines_made, chars_sent);
		$display("%0d results compared, %0d mismatches.", fixes_checked, errors);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
